// ===== rtl/twod_pkg.sv =====
// Shared types, constants and register codes for the two-wheel odometry distance block.
package twod_pkg;

	localparam int ENC_W           = 15;
	localparam int COUNT_W         = 32;
	localparam int DIST_W          = 35;
	localparam int COUNTS_PER_TURN = 32768;
	localparam int TURN_SHIFT      = $clog2(COUNTS_PER_TURN);
	localparam int WARMUP_SAMPLES  = 4;
	localparam int WARM_W          = 3;
	localparam int DELTA_W         = ENC_W + 2;
	localparam int FIFO_DEPTH      = 4;

	localparam logic signed [DELTA_W-1:0] TURN      = DELTA_W'(COUNTS_PER_TURN);
	localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(COUNTS_PER_TURN / 2);

	// product unit: 64 x 64 over four 32 x 32 partial products
	localparam int MUL_W  = 64;
	localparam int PROD_W = 2 * MUL_W;

	// skew products and magnitudes
	localparam int SKEW_W = 51;
	localparam int MA_W   = COUNT_W + 16;
	localparam int MB_W   = SKEW_W;

	// v = (m * radius) >> (turn shift + 16)
	localparam int V_SHIFT = TURN_SHIFT + 16;
	localparam int V_W     = 45;
	localparam int MM_W    = 41;
	localparam int SQ_W    = 2 * DIST_W + 1;

	// 2*pi in Q32, then round at bit 39
	localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
	localparam int          MM_SHIFT   = 40;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// root: two result bits per cycle over a radicand padded to a multiple of four bits
	localparam int ROOT_CYCLES = (DIST_W + 1) / 2;
	localparam int RAD_W       = 4 * ROOT_CYCLES;
	localparam int ROOT_W      = 2 * ROOT_CYCLES;
	localparam int REM_W       = ROOT_W + 3;

	typedef enum logic [1:0] {
		REG_SECANT,
		REG_TANGENT,
		REG_RADIUS_A,
		REG_RADIUS_B
	} reg_idx_t;

	typedef struct packed {
		logic        [17:0] secant;
		logic signed [17:0] tangent;
		logic        [23:0] radius_a;
		logic        [23:0] radius_b;
	} cfg_t;

	typedef struct packed {
		logic signed [COUNT_W-1:0] count_a;
		logic signed [COUNT_W-1:0] count_b;
	} counts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SKEW,
		S_TAN,
		S_DIFF,
		S_MUL,
		S_SUM,
		S_ROOT,
		S_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		M_RAD_A,
		M_PI_A,
		M_RAD_B,
		M_PI_B,
		M_SQ_A,
		M_SQ_B
	} mul_step_t;

endpackage

// ===== rtl/twod_front.sv =====
// Front end: takes encoder samples, forms wrapped deltas and keeps the running counts.
module twod_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [twod_pkg::ENC_W-1:0]    enc_a,
	input  logic [twod_pkg::ENC_W-1:0]    enc_b,
	input  logic                          clr,
	output logic                          push,
	output twod_pkg::counts_t             push_data,
	input  logic                          full
);

	logic [twod_pkg::ENC_W-1:0]          prev_a_q, prev_b_q;
	logic [twod_pkg::WARM_W-1:0]         warm_q;
	logic signed [twod_pkg::COUNT_W-1:0] cnt_a_q, cnt_b_q;
	logic signed [twod_pkg::DELTA_W-1:0] da, db;
	logic signed [twod_pkg::COUNT_W-1:0] new_a, new_b;
	logic                                warming;

	function automatic logic signed [twod_pkg::DELTA_W-1:0] wrap_delta(
		input logic [twod_pkg::ENC_W-1:0] cur,
		input logic [twod_pkg::ENC_W-1:0] prev
	);
		logic signed [twod_pkg::DELTA_W-1:0] d;
		d = $signed({2'b00, cur}) - $signed({2'b00, prev});
		if (d > twod_pkg::HALF_TURN) begin
			d = d - twod_pkg::TURN;
		end
		if (d < -twod_pkg::HALF_TURN) begin
			d = d + twod_pkg::TURN;
		end
		return d;
	endfunction

	assign in_ready = !full;
	assign push     = in_valid && !full;
	assign warming  = warm_q < twod_pkg::WARM_W'(twod_pkg::WARMUP_SAMPLES);

	always_comb begin
		da = '0;
		db = '0;
		if (!warming) begin
			da = wrap_delta(enc_a, prev_a_q);
			db = wrap_delta(enc_b, prev_b_q);
		end
		new_a = cnt_a_q + twod_pkg::COUNT_W'(da);
		new_b = cnt_b_q + twod_pkg::COUNT_W'(db);
		push_data.count_a = new_a;
		push_data.count_b = new_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= '0;
			prev_b_q <= '0;
			warm_q   <= '0;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
		end else if (push) begin
			prev_a_q <= enc_a;
			prev_b_q <= enc_b;
			if (warming) begin
				warm_q <= warm_q + twod_pkg::WARM_W'(1);
			end
			// clear lands after this sample's counts have gone to the queue
			cnt_a_q <= clr ? '0 : new_a;
			cnt_b_q <= clr ? '0 : new_b;
		end
	end

endmodule

// ===== rtl/twod_fifo.sv =====
// Small count queue between the front end and the arithmetic back end.
module twod_fifo #(
	parameter int DEPTH = twod_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  twod_pkg::counts_t wdata,
	input  logic              pop,
	output twod_pkg::counts_t rdata,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	twod_pkg::counts_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/twod_mul.sv =====
// Shared 64 x 64 multiplier: one 32 x 32 partial product per cycle, four partial products in all.
module twod_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [twod_pkg::MUL_W-1:0]  a,
	input  logic [twod_pkg::MUL_W-1:0]  b,
	output logic                        done,
	output logic [twod_pkg::PROD_W-1:0] prod
);

	localparam int HW = twod_pkg::MUL_W / 2;

	logic [twod_pkg::MUL_W-1:0]  a_q, b_q;
	logic [twod_pkg::PROD_W-1:0] acc_q;
	logic [1:0]                  step_q;
	logic                        run_q, done_q;
	logic [HW-1:0]               a_dig, b_dig;
	logic [2*HW-1:0]             pp;
	logic [1:0]                  wsel;
	logic [twod_pkg::PROD_W-1:0] pp_sh;

	always_comb begin
		a_dig = step_q[0] ? a_q[twod_pkg::MUL_W-1:HW] : a_q[HW-1:0];
		b_dig = step_q[1] ? b_q[twod_pkg::MUL_W-1:HW] : b_q[HW-1:0];
		pp    = a_dig * b_dig;
		wsel  = {1'b0, step_q[0]} + {1'b0, step_q[1]};
		pp_sh = twod_pkg::PROD_W'(pp) << (wsel * HW);
	end

	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/twod_sqrt.sv =====
// Integer square root, restoring digit method, two result bits per cycle.
module twod_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2*twod_pkg::DIST_W-1:0]  radicand,
	output logic                           done,
	output logic [twod_pkg::DIST_W-1:0]    root
);

	localparam int RW = twod_pkg::REM_W;
	localparam int QW = twod_pkg::ROOT_W;
	localparam int CW = $clog2(twod_pkg::ROOT_CYCLES);

	logic [twod_pkg::RAD_W-1:0] s_q;
	logic [RW-1:0]              rem_q, rem1, rem2;
	logic [QW-1:0]              root_q, root1, root2;
	logic [CW-1:0]              cnt_q;
	logic                       run_q, done_q;

	function automatic logic [RW+QW-1:0] root_step(
		input logic [RW-1:0] rem,
		input logic [QW-1:0] rt,
		input logic [1:0]    pair
	);
		logic [RW-1:0] r2, trial;
		r2    = {rem[RW-3:0], pair};
		trial = {1'b0, rt, 2'b01};
		if (r2 >= trial) begin
			return {r2 - trial, rt[QW-2:0], 1'b1};
		end
		return {r2, rt[QW-2:0], 1'b0};
	endfunction

	always_comb begin
		{rem1, root1} = root_step(rem_q, root_q,
			s_q[twod_pkg::RAD_W-1 -: 2]);
		{rem2, root2} = root_step(rem1, root1,
			s_q[twod_pkg::RAD_W-3 -: 2]);
	end

	assign done = done_q;
	assign root = root_q[twod_pkg::DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			s_q    <= twod_pkg::RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			s_q    <= s_q << 4;
			rem_q  <= rem2;
			root_q <= root2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(twod_pkg::ROOT_CYCLES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/twod_back.sv =====
// Back end: skew correction, scaling to millimetres, root of squares, output register.
module twod_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  twod_pkg::cfg_t              cfg,
	input  logic                        empty,
	input  twod_pkg::counts_t           head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [twod_pkg::DIST_W-1:0] out_dist
);

	twod_pkg::back_state_t state_q, state_d;
	twod_pkg::mul_step_t   mstep_q;

	logic signed [twod_pkg::COUNT_W-1:0] ca_q, cb_q;
	logic signed [twod_pkg::SKEW_W-1:0]  psec_q, ptan_q;
	logic signed [twod_pkg::SKEW_W-1:0]  sec_w, tan_w, ca_w, cb_w;
	logic signed [twod_pkg::SKEW_W:0]    rb;
	logic [twod_pkg::COUNT_W-1:0]        abs_a;
	logic [twod_pkg::MA_W-1:0]           ma_q;
	logic [twod_pkg::MB_W-1:0]           mb_q, abs_b;
	logic [twod_pkg::V_W-1:0]            v_q;
	logic [twod_pkg::MM_W-1:0]           mma_q, mmb_q, mm;
	logic [twod_pkg::SQ_W-1:0]           sqa_q, sqb_q;
	logic [twod_pkg::SQ_W:0]             sum;
	logic                                sat;
	logic [twod_pkg::DIST_W-1:0]         res_q, dist_q, root;
	logic                                out_valid_q, mwait_q;
	logic                                mul_start, mul_done, root_start, root_done, out_load;
	logic [twod_pkg::MUL_W-1:0]          mul_a, mul_b;
	logic [twod_pkg::PROD_W-1:0]         prod;

	twod_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	twod_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sum[2*twod_pkg::DIST_W-1:0]),
		.done     (root_done),
		.root     (root)
	);

	// skew operands and difference, magnitudes, the rounded millimetre value, sum of squares and saturation test
	always_comb begin
		sec_w = $signed(twod_pkg::SKEW_W'(cfg.secant));
		tan_w = twod_pkg::SKEW_W'(cfg.tangent);
		ca_w  = twod_pkg::SKEW_W'(ca_q);
		cb_w  = twod_pkg::SKEW_W'(cb_q);
		rb    = (twod_pkg::SKEW_W + 1)'(psec_q) - (twod_pkg::SKEW_W + 1)'(ptan_q);
		abs_b = rb[twod_pkg::SKEW_W] ? twod_pkg::MB_W'(-rb) : twod_pkg::MB_W'(rb);
		abs_a = ca_q[twod_pkg::COUNT_W-1] ? twod_pkg::COUNT_W'(-ca_q)
			: twod_pkg::COUNT_W'(ca_q);
		mm    = prod[twod_pkg::MM_SHIFT +: twod_pkg::MM_W]
			+ twod_pkg::MM_W'(prod[twod_pkg::MM_SHIFT-1]);
		sum   = {1'b0, sqa_q} + {1'b0, sqb_q};
		sat   = (mma_q[twod_pkg::MM_W-1:twod_pkg::DIST_W] != '0)
			|| (mmb_q[twod_pkg::MM_W-1:twod_pkg::DIST_W] != '0)
			|| (sum[twod_pkg::SQ_W:2*twod_pkg::DIST_W] != '0);
	end

	always_comb begin
		unique case (mstep_q)
			twod_pkg::M_RAD_A: begin
				mul_a = twod_pkg::MUL_W'(ma_q);
				mul_b = twod_pkg::MUL_W'(cfg.radius_a);
			end
			twod_pkg::M_PI_A, twod_pkg::M_PI_B: begin
				mul_a = twod_pkg::MUL_W'(v_q);
				mul_b = twod_pkg::MUL_W'(twod_pkg::TWO_PI_Q32);
			end
			twod_pkg::M_RAD_B: begin
				mul_a = twod_pkg::MUL_W'(mb_q);
				mul_b = twod_pkg::MUL_W'(cfg.radius_b);
			end
			twod_pkg::M_SQ_A: begin
				mul_a = twod_pkg::MUL_W'(mma_q);
				mul_b = twod_pkg::MUL_W'(mma_q);
			end
			twod_pkg::M_SQ_B: begin
				mul_a = twod_pkg::MUL_W'(mmb_q);
				mul_b = twod_pkg::MUL_W'(mmb_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		mul_start  = 1'b0;
		root_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			twod_pkg::S_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = twod_pkg::S_SKEW;
				end
			end
			twod_pkg::S_SKEW: state_d = twod_pkg::S_TAN;
			twod_pkg::S_TAN:  state_d = twod_pkg::S_DIFF;
			twod_pkg::S_DIFF: state_d = twod_pkg::S_MUL;
			twod_pkg::S_MUL: begin
				mul_start = !mwait_q;
				if (mul_done && mstep_q == twod_pkg::M_SQ_B) begin
					state_d = twod_pkg::S_SUM;
				end
			end
			twod_pkg::S_SUM: begin
				if (sat) begin
					state_d = twod_pkg::S_OUT;
				end else begin
					root_start = 1'b1;
					state_d    = twod_pkg::S_ROOT;
				end
			end
			twod_pkg::S_ROOT: begin
				if (root_done) begin
					state_d = twod_pkg::S_OUT;
				end
			end
			twod_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = twod_pkg::S_IDLE;
				end
			end
			default: state_d = twod_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twod_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q     <= twod_pkg::M_RAD_A;
			mwait_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == twod_pkg::S_DIFF) begin
				mstep_q <= twod_pkg::M_RAD_A;
				mwait_q <= 1'b0;
			end else if (mul_start) begin
				mwait_q <= 1'b1;
			end else if (mul_done) begin
				mwait_q <= 1'b0;
				if (mstep_q != twod_pkg::M_SQ_B) begin
					mstep_q <= twod_pkg::mul_step_t'(mstep_q + 3'd1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ca_q <= head.count_a;
			cb_q <= head.count_b;
		end
		if (state_q == twod_pkg::S_SKEW) begin
			psec_q <= sec_w * cb_w;
		end
		if (state_q == twod_pkg::S_TAN) begin
			ptan_q <= tan_w * ca_w;
		end
		if (state_q == twod_pkg::S_DIFF) begin
			ma_q <= {abs_a, 16'd0};
			mb_q <= abs_b;
		end
		if (mul_done) begin
			unique case (mstep_q)
				twod_pkg::M_RAD_A, twod_pkg::M_RAD_B:
					v_q <= prod[twod_pkg::V_SHIFT +: twod_pkg::V_W];
				twod_pkg::M_PI_A: mma_q <= mm;
				twod_pkg::M_PI_B: mmb_q <= mm;
				twod_pkg::M_SQ_A: sqa_q <= prod[twod_pkg::SQ_W-1:0];
				twod_pkg::M_SQ_B: sqb_q <= prod[twod_pkg::SQ_W-1:0];
				default: ;
			endcase
		end
		if (state_q == twod_pkg::S_SUM && sat) begin
			res_q <= twod_pkg::DIST_MAX;
		end else if (state_q == twod_pkg::S_ROOT && root_done) begin
			res_q <= root;
		end
		if (out_load) begin
			dist_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_dist  = dist_q;

	// a product only comes back when one was issued
	a_mul_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (mwait_q && state_q == twod_pkg::S_MUL))
		else $error("product returned with none outstanding");

	// the root unit only finishes while the sequencer waits for it
	a_root_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == twod_pkg::S_ROOT)
		else $error("root finished outside root state");

	// a popped count pair is worked on in the next cycle
	a_pop_next: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == twod_pkg::S_SKEW)
		else $error("pop not followed by skew step");

	// no result is overwritten while still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(dist_q))
		else $error("pending distance overwritten");

endmodule

// ===== rtl/two_wheel_odometry_distance.sv =====
// Top level of the two-wheel odometry distance block: ports, configuration registers, wiring.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready| tdata: encoder_a, encoder_b; tuser: clear_sums
//  m_axis    | out       | m_axis_tvalid / m_axis_tready| tdata: distance
//  cfg       | in        | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// The front end takes one sample per cycle while the queue has room; the back end takes
// no new sample until it is done with the last: six products on the one shared 32 x 32
// multiplier, then the root, which is skipped when the result saturates.
// Reset is asynchronous, active low: counts, warm-up, queue and sequencer clear;
// configuration returns to secant 1.0, tangent 0, radii 0.
// A stalled output holds its result; the back end waits at the output register, the
// queue fills, and only then does s_axis_tready drop.
module two_wheel_odometry_distance #(
	parameter int FIFO_DEPTH = twod_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [14:0] encoder_a, [29:15] encoder_b, [31:30] zero
	input  logic [0:0]  s_axis_tuser,  // [0] clear_sums
	// distance stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [34:0] distance, [39:35] zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	twod_pkg::cfg_t              cfg_q;
	twod_pkg::counts_t           push_data, head;
	logic                        push, pop, full, empty;
	logic [twod_pkg::DIST_W-1:0] distance;

	// writes are taken at once; the user must write only while the block is idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.secant   <= 18'h10000;
			cfg_q.tangent  <= '0;
			cfg_q.radius_a <= '0;
			cfg_q.radius_b <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (twod_pkg::reg_idx_t'(cfg_index))
				twod_pkg::REG_SECANT:   cfg_q.secant   <= cfg_data[17:0];
				twod_pkg::REG_TANGENT:  cfg_q.tangent  <= $signed(cfg_data[17:0]);
				twod_pkg::REG_RADIUS_A: cfg_q.radius_a <= cfg_data;
				twod_pkg::REG_RADIUS_B: cfg_q.radius_b <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: deltas, warm-up and the running counts, one sample per cycle while the queue has room
	twod_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.enc_a     (s_axis_tdata[14:0]),
		.enc_b     (s_axis_tdata[29:15]),
		.clr       (s_axis_tuser[0]),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// count pairs wait here for the back end
	twod_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	// back end: skew, scaling, root of squares and the output register
	twod_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_dist  (distance)
	);

	assign m_axis_tdata = {5'd0, distance};

endmodule
